[rtl/bplc_pkg.sv]
`timescale 1ns / 1ps

package bplc_pkg;

    localparam int CNT_W   = 16;
    localparam int PHASE_W = CNT_W + 1;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] PAIR_HOLD_RST    = 16'd3000;
    localparam logic [CNT_W-1:0] SLEEP_HOLD_RST   = 16'd5000;
    localparam logic [CNT_W-1:0] PAIR_TIMEOUT_RST = 16'd20000;
    localparam logic [CNT_W-1:0] PAIR_BLINK_RST   = 16'd150;
    localparam logic [CNT_W-1:0] IDLE_ON_RST      = 16'd80;
    localparam logic [CNT_W-1:0] IDLE_OFF_RST     = 16'd2000;

    // register index (paddr[4:2])
    localparam logic [2:0] REG_PAIR_HOLD    = 3'd0;
    localparam logic [2:0] REG_SLEEP_HOLD   = 3'd1;
    localparam logic [2:0] REG_PAIR_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_PAIR_BLINK   = 3'd3;
    localparam logic [2:0] REG_IDLE_ON      = 3'd4;
    localparam logic [2:0] REG_IDLE_OFF     = 3'd5;

    localparam logic [1:0] REQ_NONE   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_STOP   = 2'd2;
    localparam logic [1:0] REQ_TOGGLE = 2'd3;

    typedef struct packed {
        logic       button_down;
        logic       link_up;
        logic       link_connect_pulse;
        logic [1:0] pair_request;
    } tick_t;

    typedef struct packed {
        logic led_on;
        logic pairing_active;
        logic pairing_started;
        logic pairing_stopped;
        logic sleep_request;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] pair_hold_ms;
        logic [CNT_W-1:0] sleep_hold_lim;
        logic [CNT_W-1:0] pair_timeout_ms;
        logic [CNT_W-1:0] pair_blink_ms;
        logic [CNT_W-1:0] idle_on_ms;
        logic [CNT_W-1:0] idle_off_ms;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]   hold_ticks;
        logic               button_was_up;
        logic               sleep_fired;
        logic               pair_mode;
        logic [CNT_W-1:0]   pair_elapsed;
        logic [CNT_W-1:0]   blink_elapsed;
        logic               led_level;
        logic               blink_level;
        logic [PHASE_W-1:0] idle_phase;
    } state_t;

    localparam state_t STATE_RST = '{
        hold_ticks:    '0,
        button_was_up: 1'b1,
        sleep_fired:   1'b0,
        pair_mode:     1'b0,
        pair_elapsed:  '0,
        blink_elapsed: '0,
        led_level:     1'b0,
        blink_level:   1'b0,
        idle_phase:    '0
    };

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? CNT_MAX : x + CNT_W'(1);
    endfunction

endpackage

[rtl/bplc_tick_logic.sv]
`timescale 1ns / 1ps

module bplc_tick_logic
    import bplc_pkg::*;
(
    input  state_t  cur_state,
    input  cfg_t    cfg,
    input  tick_t   tick,
    output state_t  next_state,
    output result_t result
);

    always_comb
    begin
        state_t             s;
        logic               pressed;
        logic               linked;
        logic               ev_start;
        logic               ev_stop;
        logic               slp;
        logic [PHASE_W-1:0] period;
        logic [PHASE_W:0]   phase_inc;

        s         = cur_state;
        pressed   = tick.button_down;
        linked    = tick.link_up | tick.link_connect_pulse;
        ev_start  = 1'b0;
        ev_stop   = 1'b0;
        slp       = 1'b0;
        period    = {1'b0, cfg.idle_on_ms} + {1'b0, cfg.idle_off_ms};
        phase_inc = {1'b0, s.idle_phase} + (PHASE_W+1)'(1);

        s.pair_elapsed  = inc_sat(s.pair_elapsed);
        s.blink_elapsed = inc_sat(s.blink_elapsed);
        if (phase_inc >= {1'b0, period})
        begin
            s.idle_phase = '0;
        end
        else
        begin
            s.idle_phase = phase_inc[PHASE_W-1:0];
        end

        if (tick.link_connect_pulse)
        begin
            if (s.pair_mode)
            begin
                ev_stop = 1'b1;
            end
            s.pair_mode = 1'b0;
            s.led_level = 1'b0;
        end

        case (tick.pair_request)
            REQ_NONE:
            begin
            end
            REQ_START:
            begin
                if (linked)
                begin
                    s.pair_mode    = 1'b1;
                    s.pair_elapsed = '0;
                    ev_start       = 1'b1;
                end
            end
            REQ_STOP:
            begin
                if (linked)
                begin
                    s.pair_mode = 1'b0;
                    s.led_level = 1'b0;
                    ev_stop     = 1'b1;
                end
            end
            REQ_TOGGLE:
            begin
                if (s.pair_mode)
                begin
                    s.pair_mode = 1'b0;
                    s.led_level = 1'b0;
                    ev_stop     = 1'b1;
                end
                else
                begin
                    s.pair_mode    = 1'b1;
                    s.pair_elapsed = '0;
                    ev_start       = 1'b1;
                end
            end
        endcase

        if (pressed)
        begin
            if (s.button_was_up)
            begin
                s.hold_ticks    = '0;
                s.button_was_up = 1'b0;
                s.sleep_fired   = 1'b0;
            end
            else
            begin
                s.hold_ticks = inc_sat(s.hold_ticks);
            end
            if (!s.pair_mode)
            begin
                s.led_level = 1'b1;
            end
            if (!s.sleep_fired && s.hold_ticks >= cfg.sleep_hold_lim)
            begin
                s.sleep_fired = 1'b1;
                slp           = 1'b1;
                s.pair_mode   = 1'b0;
            end
        end
        else
        begin
            if (!s.button_was_up)
            begin
                s.hold_ticks = inc_sat(s.hold_ticks);
                if (!s.sleep_fired && s.hold_ticks >= cfg.pair_hold_ms)
                begin
                    if (s.pair_mode)
                    begin
                        s.pair_mode = 1'b0;
                        s.led_level = 1'b0;
                        ev_stop     = 1'b1;
                    end
                    else
                    begin
                        s.pair_mode    = 1'b1;
                        s.pair_elapsed = '0;
                        ev_start       = 1'b1;
                    end
                end
            end
            if (!s.pair_mode)
            begin
                s.led_level = 1'b0;
            end
            s.button_was_up = 1'b1;
            s.sleep_fired   = 1'b0;
        end

        if (s.pair_mode && !pressed)
        begin
            if (s.pair_elapsed >= cfg.pair_timeout_ms)
            begin
                s.pair_mode = 1'b0;
                s.led_level = 1'b0;
                ev_stop     = 1'b1;
            end
            else if (s.blink_elapsed >= cfg.pair_blink_ms)
            begin
                s.blink_elapsed = '0;
                s.blink_level   = !s.blink_level;
                s.led_level     = s.blink_level;
            end
        end

        if (!linked && !s.pair_mode && !pressed)
        begin
            s.led_level = (s.idle_phase < {1'b0, cfg.idle_on_ms});
        end

        next_state             = s;
        result.led_on          = s.led_level;
        result.pairing_active  = s.pair_mode;
        result.pairing_started = ev_start;
        result.pairing_stopped = ev_stop;
        result.sleep_request   = slp;
    end

endmodule

[rtl/button_pairing_led_controller_core.sv]
// Channel | Direction | Handshake                  | Payload
// tick    | in        | tick_valid / tick_stall     | tick   (tick_t)
// result  | out       | result_valid / result_stall | result (result_t)
// config  | in        | APB psel/penable/pwrite     | 6 x 16-bit registers at 4*i
//
// One tick per clock cycle sustained unless the result stalls; a tick passes the
// input register, then the tick logic feeding the result and state registers.
// The state update is one combinational pass, which sets the rate.
// Reset (rst_n low, asynchronous) clears the pipeline and loads default timings.
// A stalled result holds the pipeline; ticks are taken while the input
// register is empty or moving on.
`timescale 1ns / 1ps

module button_pairing_led_controller_core
    import bplc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              tick_valid,
    output logic              tick_stall,
    input  tick_t             tick,

    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    logic    result_valid_reg;
    logic    load_result;
    logic    take_tick;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{
                pair_hold_ms:    PAIR_HOLD_RST,
                sleep_hold_lim:  SLEEP_HOLD_RST,
                pair_timeout_ms: PAIR_TIMEOUT_RST,
                pair_blink_ms:   PAIR_BLINK_RST,
                idle_on_ms:      IDLE_ON_RST,
                idle_off_ms:     IDLE_OFF_RST
            };
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_PAIR_HOLD:    cfg_reg.pair_hold_ms    <= pwdata[CNT_W-1:0];
                REG_SLEEP_HOLD:   cfg_reg.sleep_hold_lim  <= pwdata[CNT_W-1:0];
                REG_PAIR_TIMEOUT: cfg_reg.pair_timeout_ms <= pwdata[CNT_W-1:0];
                REG_PAIR_BLINK:   cfg_reg.pair_blink_ms   <= pwdata[CNT_W-1:0];
                REG_IDLE_ON:      cfg_reg.idle_on_ms      <= pwdata[CNT_W-1:0];
                REG_IDLE_OFF:     cfg_reg.idle_off_ms     <= pwdata[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_PAIR_HOLD:    prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.pair_hold_ms};
            REG_SLEEP_HOLD:   prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.sleep_hold_lim};
            REG_PAIR_TIMEOUT: prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.pair_timeout_ms};
            REG_PAIR_BLINK:   prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.pair_blink_ms};
            REG_IDLE_ON:      prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.idle_on_ms};
            REG_IDLE_OFF:     prdata = {{(CFG_DW-CNT_W){1'b0}}, cfg_reg.idle_off_ms};
            default:          prdata = '0;
        endcase
    end

    assign load_result = tick_valid_reg & (~result_valid_reg | ~result_stall);
    assign take_tick   = ~tick_valid_reg | load_result;
    assign tick_stall  = ~take_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (take_tick)
        begin
            tick_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_tick && tick_valid)
        begin
            tick_reg <= tick;
        end
    end

    bplc_tick_logic u_tick_logic (
        .cur_state  (state_reg),
        .cfg        (cfg_reg),
        .tick       (tick_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= STATE_RST;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_result)
            begin
                state_reg <= state_next;
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_sleep_clears_pairing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sleep_request |-> !result.pairing_active)
        else $error("sleep request with pairing still active");

    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(load_result) |-> (state_reg.pair_mode == result.pairing_active)
                               && (state_reg.led_level == result.led_on))
        else $error("state and delivered result disagree");

    a_sleep_only_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sleep_fired |-> !state_reg.button_was_up)
        else $error("sleep flag set with button released");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid_reg && result_valid && result_stall |-> tick_stall)
        else $error("tick taken while pipeline is blocked");
`endif

endmodule
